@@ hw/rtl/qpht_pkg.sv @@
// Package for the quadratic probe hash table: widths, codes and shared types.
// Used by the interfaces, the controller, the datapath and the top level.
`timescale 1ns / 1ps
package qpht_pkg;
    localparam int unsigned SLOT_DEPTH = 1024;
    localparam int unsigned SLOT_BITS  = 10;
    localparam int unsigned KEY_BITS   = 32;
    localparam int unsigned DATA_BITS  = 32;
    localparam int unsigned CFG_BITS   = 10;
    localparam int unsigned CNT_BITS   = 10;
    localparam int unsigned CFG_IDX_BITS = 1;

    localparam logic [CFG_IDX_BITS-1:0] CFG_TABLE_SIZE = 1'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_LOAD_LIMIT = 1'd1;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    localparam logic [1:0] ST_DONE      = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;

    typedef struct packed {
        logic opcode;
        logic [KEY_BITS-1:0]  key;
        logic [DATA_BITS-1:0] payload;
    } t_req;

    typedef struct packed {
        logic [1:0]           status;
        logic [SLOT_BITS-1:0] slot;
        logic [DATA_BITS-1:0] removed_payload;
        logic [CNT_BITS-1:0]  entry_count;
    } t_rsp;

    // controller -> datapath
    typedef struct packed {
        logic clr;       // clear one used bit after reset
        logic load;      // capture request, start modulo
        logic mod_step;  // one restoring-division bit
        logic rd;        // read slot at current position
        logic advance;   // move to next probe position
        logic wr_ins;    // write slot as insert
        logic wr_rem;    // clear slot
        logic fin_ok;    // build success response
        logic fin_fail;  // build failure response
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic clr_done;
        logic opcode;
        logic mod_last;
        logic hit;        // read slot satisfies the search
        logic probes_done;
        logic at_limit;
    } t_sts;
endpackage

@@ hw/rtl/qpht_if.sv @@
// Valid/ready channel carrying a request or response payload.
// Depends on qpht_pkg.
`timescale 1ns / 1ps
interface qpht_req_if;
    logic valid;
    logic ready;
    qpht_pkg::t_req data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface qpht_rsp_if;
    logic valid;
    logic ready;
    qpht_pkg::t_rsp data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ hw/rtl/qpht_datapath.sv @@
// Datapath of the hash table: serial modulo, probe walk, slot memories, count.
// Depends on qpht_pkg; driven by qpht_ctrl commands.
`timescale 1ns / 1ps
module qpht_datapath (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  qpht_pkg::t_cmd               i_cmd,
    input  qpht_pkg::t_req               i_req,
    input  logic [qpht_pkg::CFG_BITS-1:0] i_table_size,
    input  logic [qpht_pkg::CFG_BITS-1:0] i_load_limit,
    output qpht_pkg::t_sts               o_sts,
    output qpht_pkg::t_rsp               o_rsp
);
    localparam int unsigned SB = qpht_pkg::SLOT_BITS;
    localparam int unsigned KB = qpht_pkg::KEY_BITS;
    localparam int unsigned DB = qpht_pkg::DATA_BITS;
    localparam int unsigned SZB = SB + 1;
    localparam int unsigned KCB = $clog2(KB + 1);

    logic [SZB-1:0] size_c;
    logic [SZB-1:0] r_size, n_size;
    logic [SB-1:0]  r_limit, n_limit;
    logic [KB-1:0]  r_key, n_key;
    logic [KB-1:0]  r_quo, n_quo;
    logic [DB-1:0]  r_data, n_data;
    logic           r_op, n_op;
    logic [SZB-1:0] r_rem, n_rem;
    logic [KCB-1:0] r_bit, n_bit;
    logic [SB-1:0]  r_pos, n_pos;
    logic [SB-1:0]  r_i, n_i;
    logic [SB-1:0]  r_clr_addr, n_clr_addr;
    logic [qpht_pkg::CNT_BITS-1:0] r_count, n_count;
    qpht_pkg::t_rsp r_rsp, n_rsp;

    logic          mem_used [qpht_pkg::SLOT_DEPTH];
    logic [KB-1:0] mem_key [qpht_pkg::SLOT_DEPTH];
    logic [DB-1:0] mem_data [qpht_pkg::SLOT_DEPTH];
    logic [KB-1:0] r_rd_key;
    logic [DB-1:0] r_rd_data;
    logic          r_rd_used;

    logic          used_we;
    logic          used_val;
    logic [SB-1:0] used_addr;

    logic [SZB:0]   trial;
    logic [SZB+1:0] npos;

    always_comb begin
        if (i_table_size < 10'd3) size_c = SZB'(3);
        else size_c = SZB'(i_table_size);
        trial = {r_rem, r_quo[KB-1]} ;
        npos = (SZB+2)'(r_pos) + (SZB+2)'({r_i, 1'b1});
        if (npos >= (SZB+2)'(r_size)) npos = npos - (SZB+2)'(r_size);
        used_we = i_cmd.clr || i_cmd.wr_ins || i_cmd.wr_rem;
        used_val = i_cmd.wr_ins;
        used_addr = i_cmd.clr ? r_clr_addr : r_pos;
    end

    always_comb begin
        n_size = r_size; n_limit = r_limit; n_key = r_key; n_quo = r_quo;
        n_data = r_data; n_op = r_op; n_rem = r_rem; n_bit = r_bit;
        n_pos = r_pos; n_i = r_i; n_count = r_count; n_rsp = r_rsp;
        n_clr_addr = r_clr_addr;
        if (i_cmd.clr) n_clr_addr = r_clr_addr + SB'(1);
        if (i_cmd.load) begin
            n_size = size_c;
            n_limit = SB'((size_c + SZB'(1)) >> 1);
            n_key = i_req.key; n_quo = i_req.key; n_data = i_req.payload;
            n_op = i_req.opcode; n_rem = '0; n_bit = '0; n_i = '0;
        end
        if (i_cmd.mod_step) begin
            n_quo = {r_quo[KB-2:0], 1'b0};
            if (trial >= (SZB+1)'(r_size)) n_rem = SZB'(trial - (SZB+1)'(r_size));
            else n_rem = SZB'(trial);
            n_bit = r_bit + KCB'(1);
            n_pos = SB'(n_rem);
        end
        if (i_cmd.advance) begin
            n_pos = SB'(npos);
            n_i = r_i + SB'(1);
        end
        if (i_cmd.wr_ins) n_count = r_count + qpht_pkg::CNT_BITS'(1);
        if (i_cmd.wr_rem && r_count != '0) n_count = r_count - qpht_pkg::CNT_BITS'(1);
        if (i_cmd.fin_ok) begin
            n_rsp.status = qpht_pkg::ST_DONE;
            n_rsp.slot = r_pos;
            n_rsp.removed_payload = (r_op == qpht_pkg::OP_REMOVE) ? r_rd_data : '0;
            n_rsp.entry_count = r_count;
        end
        if (i_cmd.fin_fail) begin
            n_rsp.status = (r_op == qpht_pkg::OP_REMOVE) ? qpht_pkg::ST_NOT_FOUND
                                                         : qpht_pkg::ST_FULL;
            n_rsp.slot = '0;
            n_rsp.removed_payload = '0;
            n_rsp.entry_count = r_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_size <= n_size; r_limit <= n_limit; r_key <= n_key; r_quo <= n_quo;
        r_data <= n_data; r_op <= n_op; r_rem <= n_rem; r_bit <= n_bit;
        r_pos <= n_pos; r_i <= n_i; r_rsp <= n_rsp;
        if (!i_rst_n) begin
            r_count <= '0;
            r_clr_addr <= '0;
        end else begin
            r_count <= n_count;
            r_clr_addr <= n_clr_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (used_we) mem_used[used_addr] <= used_val;
        if (i_cmd.wr_ins) begin
            mem_key[r_pos] <= r_key;
            mem_data[r_pos] <= r_data;
        end
        if (i_cmd.rd) begin
            r_rd_key <= mem_key[r_pos];
            r_rd_data <= mem_data[r_pos];
            r_rd_used <= mem_used[r_pos];
        end
    end

    always_comb begin
        o_sts.clr_done = (r_clr_addr == SB'(qpht_pkg::SLOT_DEPTH - 1));
        o_sts.opcode = r_op;
        o_sts.mod_last = (r_bit == KCB'(KB - 1));
        o_sts.hit = (r_op == qpht_pkg::OP_REMOVE) ? (r_rd_used && r_rd_key == r_key)
                                                  : !r_rd_used;
        o_sts.probes_done = (r_i + SB'(1) >= r_limit);
        o_sts.at_limit = (r_count >= i_load_limit);
        o_rsp = r_rsp;
    end
endmodule

@@ hw/rtl/qpht_ctrl.sv @@
// Controller state machine for the hash table: sequences modulo, probes, writes.
// Depends on qpht_pkg; drives qpht_datapath.
`timescale 1ns / 1ps
module qpht_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_req_valid,
    output logic           o_req_ready,
    output logic           o_rsp_valid,
    input  logic           i_rsp_ready,
    input  qpht_pkg::t_sts i_sts,
    output qpht_pkg::t_cmd o_cmd
);
    typedef enum logic [7:0] {
        S_CLEAR = 8'b00000001,
        S_IDLE  = 8'b00000010,
        S_MOD   = 8'b00000100,
        S_READ  = 8'b00001000,
        S_CHECK = 8'b00010000,
        S_WRITE = 8'b00100000,
        S_FIN   = 8'b01000000,
        S_RESP  = 8'b10000000
    } t_state;

    t_state r_state, n_state;
    logic   r_ok, n_ok;

    always_comb begin
        n_state = r_state;
        n_ok = r_ok;
        o_cmd = '0;
        o_req_ready = (r_state == S_IDLE);
        o_rsp_valid = (r_state == S_RESP);
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr = 1'b1;
                if (i_sts.clr_done) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_req_valid) begin
                    o_cmd.load = 1'b1;
                    n_state = S_MOD;
                end
            end
            S_MOD: begin
                o_cmd.mod_step = 1'b1;
                if (i_sts.mod_last) begin
                    if (i_sts.opcode == qpht_pkg::OP_INSERT && i_sts.at_limit) begin
                        n_ok = 1'b0;
                        n_state = S_FIN;
                    end else n_state = S_READ;
                end
            end
            S_READ: begin
                o_cmd.rd = 1'b1;
                n_state = S_CHECK;
            end
            S_CHECK: begin
                if (i_sts.hit) n_state = S_WRITE;
                else if (i_sts.probes_done) begin
                    n_ok = 1'b0;
                    n_state = S_FIN;
                end else begin
                    o_cmd.advance = 1'b1;
                    n_state = S_READ;
                end
            end
            S_WRITE: begin
                o_cmd.wr_ins = (i_sts.opcode == qpht_pkg::OP_INSERT);
                o_cmd.wr_rem = (i_sts.opcode == qpht_pkg::OP_REMOVE);
                n_ok = 1'b1;
                n_state = S_FIN;
            end
            S_FIN: begin
                o_cmd.fin_ok = r_ok;
                o_cmd.fin_fail = !r_ok;
                n_state = S_RESP;
            end
            S_RESP: begin
                if (i_rsp_ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_ok <= n_ok;
        if (!i_rst_n) r_state <= S_CLEAR;
        else r_state <= n_state;
    end
endmodule

@@ hw/rtl/quadratic_probe_hash_table.sv @@
// Top level of the quadratic probe hash table: config registers, controller, datapath.
// Depends on qpht_pkg, qpht_if, qpht_ctrl and qpht_datapath.
// After reset a clearing pass empties the slot store; requests are held off
// until it ends. Then one request at a time: a bit-serial key modulo table size,
// then per probe a registered slot read and a compare, up to (size+1)/2 probes,
// then a write, a step to build the response and the response itself, which
// waits for ready. A failed search skips the write, and an insert refused at
// the load limit skips the probes and the write.
`timescale 1ns / 1ps
module quadratic_probe_hash_table (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_cfg_we,
    input  logic [qpht_pkg::CFG_IDX_BITS-1:0] i_cfg_idx,
    input  logic [qpht_pkg::CFG_BITS-1:0]     i_cfg_data,
    qpht_req_if.sink   req,
    qpht_rsp_if.source rsp
);
    logic [qpht_pkg::CFG_BITS-1:0] r_table_size, r_load_limit;
    qpht_pkg::t_cmd cmd;
    qpht_pkg::t_sts sts;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_table_size <= 10'd31;
            r_load_limit <= 10'd15;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                qpht_pkg::CFG_TABLE_SIZE: r_table_size <= i_cfg_data;
                qpht_pkg::CFG_LOAD_LIMIT: r_load_limit <= i_cfg_data;
                default: ;
            endcase
        end
    end

    qpht_ctrl u_ctrl (
        .i_clk, .i_rst_n,
        .i_req_valid(req.valid), .o_req_ready(req.ready),
        .o_rsp_valid(rsp.valid), .i_rsp_ready(rsp.ready),
        .i_sts(sts), .o_cmd(cmd)
    );

    qpht_datapath u_dp (
        .i_clk, .i_rst_n, .i_cmd(cmd), .i_req(req.data),
        .i_table_size(r_table_size), .i_load_limit(r_load_limit),
        .o_sts(sts), .o_rsp(rsp.data)
    );

    a_one_hot_wr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(cmd.wr_ins && cmd.wr_rem)) else $error("insert and remove write together");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(req.ready && rsp.valid)) else $error("request taken while response pending");
    a_fail_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rsp.valid && rsp.data.status != qpht_pkg::ST_DONE |-> rsp.data.slot == '0)
        else $error("failed request reports a slot");
endmodule

@@ bench/qpht_table_checker.sv @@
// Checker for the quadratic probe hash table: predicts each response from the
// accepted requests and config writes, then compares field by field.
// Depends on qpht_pkg and qpht_if.
`timescale 1ns / 1ps
module qpht_table_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_cfg_we,
    input  logic [qpht_pkg::CFG_IDX_BITS-1:0] i_cfg_idx,
    input  logic [qpht_pkg::CFG_BITS-1:0]     i_cfg_data,
    qpht_req_if  req,
    qpht_rsp_if  rsp,
    output int   o_fail_count
);
    import qpht_pkg::*;

    logic                 occupied [SLOT_DEPTH];
    logic [KEY_BITS-1:0]  held_key [SLOT_DEPTH];
    logic [DATA_BITS-1:0] held_data [SLOT_DEPTH];
    logic [CNT_BITS-1:0]  entries;
    logic [CFG_BITS-1:0]  size_reg;
    logic [CFG_BITS-1:0]  limit_reg;
    t_rsp                 pending_rsp [$];

    function automatic bit find_slot(input logic [KEY_BITS-1:0] k, input bit want_key,
                                     output int unsigned where);
        int unsigned span;
        int unsigned tries;
        int unsigned pos;
        span = size_reg;
        if (span < 3) span = 3;
        if (span > SLOT_DEPTH) span = SLOT_DEPTH;
        tries = (span + 1) / 2;
        pos = k % span;
        where = 0;
        for (int unsigned i = 0; i < tries; i++) begin
            if (i != 0) begin
                pos += 2 * i - 1;
                if (pos >= span) pos -= span;
            end
            if (want_key ? (occupied[pos] && held_key[pos] == k) : !occupied[pos]) begin
                where = pos;
                return 1;
            end
        end
        return 0;
    endfunction

    function automatic t_rsp apply_request(input t_req r);
        t_rsp res;
        int unsigned pos;
        res = '0;
        if (r.opcode == OP_INSERT) begin
            if (entries >= limit_reg || !find_slot(r.key, 0, pos)) begin
                res.status = ST_FULL;
            end else begin
                occupied[pos] = 1'b1;
                held_key[pos] = r.key;
                held_data[pos] = r.payload;
                entries = entries + 1'b1;
                res.status = ST_DONE;
                res.slot = pos[SLOT_BITS-1:0];
            end
        end else begin
            if (!find_slot(r.key, 1, pos)) begin
                res.status = ST_NOT_FOUND;
            end else begin
                res.removed_payload = held_data[pos];
                occupied[pos] = 1'b0;
                if (entries > 0) entries = entries - 1'b1;
                res.status = ST_DONE;
                res.slot = pos[SLOT_BITS-1:0];
            end
        end
        res.entry_count = entries;
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_rsp want;
        if (!i_rst_n) begin
            for (int i = 0; i < SLOT_DEPTH; i++) occupied[i] = 1'b0;
            entries = '0;
            size_reg = 10'd31;
            limit_reg = 10'd15;
            pending_rsp.delete();
            o_fail_count = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_TABLE_SIZE: size_reg = i_cfg_data;
                    CFG_LOAD_LIMIT: limit_reg = i_cfg_data;
                    default: ;
                endcase
            end
            if (rsp.valid && rsp.ready) begin
                if (pending_rsp.size() == 0) begin
                    $display("%0t: unexpected response %p", $time, rsp.data);
                    o_fail_count++;
                end else begin
                    want = pending_rsp.pop_front();
                    if (rsp.data.status !== want.status) begin
                        $display("%0t: status exp %0d act %0d", $time, want.status,
                                 rsp.data.status);
                        o_fail_count++;
                    end
                    if (rsp.data.slot !== want.slot) begin
                        $display("%0t: slot exp %0d act %0d", $time, want.slot, rsp.data.slot);
                        o_fail_count++;
                    end
                    if (rsp.data.removed_payload !== want.removed_payload) begin
                        $display("%0t: removed_payload exp %h act %h", $time,
                                 want.removed_payload, rsp.data.removed_payload);
                        o_fail_count++;
                    end
                    if (rsp.data.entry_count !== want.entry_count) begin
                        $display("%0t: entry_count exp %0d act %0d", $time,
                                 want.entry_count, rsp.data.entry_count);
                        o_fail_count++;
                    end
                end
            end
            if (req.valid && req.ready) pending_rsp.push_back(apply_request(req.data));
        end
    end

    final begin
        if (pending_rsp.size() != 0)
            $display("%0t: %0d responses never arrived", $time, pending_rsp.size());
    end
endmodule

@@ bench/tb.sv @@
// Testbench top for the quadratic probe hash table: clock, reset, config
// writes, request and response traffic, verdict. Depends on qpht_pkg, qpht_if,
// qpht_table_checker and quadratic_probe_hash_table.
`timescale 1ns / 1ps
module tb;
    import qpht_pkg::*;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_IDX_BITS-1:0] i_cfg_idx;
    logic [CFG_BITS-1:0]     i_cfg_data;
    int   sent_count = 0;
    int   done_count = 0;
    int   fail_count;
    int   cycle_count = 0;
    bit   idle_on = 1'b1;

    qpht_req_if req_ch();
    qpht_rsp_if rsp_ch();

    quadratic_probe_hash_table dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we),
        .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data), .req(req_ch), .rsp(rsp_ch)
    );

    qpht_table_checker checker_i (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we),
        .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data), .req(req_ch), .rsp(rsp_ch),
        .o_fail_count(fail_count)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 10000000) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic send_request(input logic op, input logic [KEY_BITS-1:0] k,
                                input logic [DATA_BITS-1:0] d);
        int gap;
        gap = idle_on ? $urandom_range(0, 3) : 0;
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.data <= '{opcode: op, key: k, payload: d};
        do @(posedge i_clk); while (!req_ch.ready);
        sent_count++;
    endtask

    task automatic drain;
        req_ch.valid <= 1'b0;
        while (done_count != sent_count) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic write_cfg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_BITS-1:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic random_phase(input int tsize, input int tlimit, input int count);
        logic [KEY_BITS-1:0] pool [12];
        int pick;
        drain();
        write_cfg(CFG_TABLE_SIZE, tsize[CFG_BITS-1:0]);
        write_cfg(CFG_LOAD_LIMIT, tlimit[CFG_BITS-1:0]);
        foreach (pool[i]) pool[i] = $urandom;
        idle_on = $urandom_range(0, 3) != 0;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 9);
            if (pick <= 4)
                send_request(OP_INSERT, pool[$urandom_range(0, 11)], $urandom);
            else if (pick <= 8)
                send_request(OP_REMOVE, pool[$urandom_range(0, 11)], $urandom);
            else
                send_request(logic'($urandom_range(0, 1)), $urandom, $urandom);
        end
    endtask

    initial begin
        rsp_ch.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            int gap;
            gap = idle_on ? $urandom_range(0, 3) : 0;
            if (gap > 0) begin
                rsp_ch.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            rsp_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!rsp_ch.valid);
            done_count++;
        end
    end

    initial begin
        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_idx <= CFG_TABLE_SIZE;
        i_cfg_data <= '0;
        req_ch.valid <= 1'b0;
        req_ch.data <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // defaults: 31 slots, limit 15
        send_request(OP_INSERT, 32'h0, 32'h0);
        send_request(OP_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(OP_INSERT, 32'd31, 32'hA5A5_5A5A);
        send_request(OP_INSERT, 32'h0, 32'h1);
        send_request(OP_REMOVE, 32'h0, 32'hFFFF_FFFF);
        send_request(OP_REMOVE, 32'h0, 32'h0);
        send_request(OP_REMOVE, 32'h0, 32'h0);
        send_request(OP_REMOVE, 32'd31, 32'h0);
        for (int i = 0; i < 15; i++)
            send_request(OP_INSERT, 32'(i * 31), 32'(i) ^ 32'h5555_5555);
        send_request(OP_REMOVE, 32'hFFFF_FFFF, 32'h0);

        random_phase(3, 1023, 120);
        random_phase(7, 5, 150);
        random_phase(0, 1023, 100);
        random_phase(13, 0, 60);
        random_phase(31, 20, 200);
        random_phase(10, 8, 150);
        random_phase(1021, 1021, 40);
        random_phase(61, 40, 200);
        random_phase(2, 1, 100);
        random_phase(17, 1023, 250);
        drain();

        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule

@@ files.f @@
hw/rtl/qpht_pkg.sv
hw/rtl/qpht_if.sv
hw/rtl/qpht_datapath.sv
hw/rtl/qpht_ctrl.sv
hw/rtl/quadratic_probe_hash_table.sv
bench/qpht_table_checker.sv
bench/tb.sv
